// ----- src/iqf_pkg.sv -----
// Shared types and constants for the I/Q integer to float32 converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package iqf_pkg;

  // Sample format codes held in the format register
  typedef enum logic [3:0] {
    FMT_CS8     = 4'd0,
    FMT_CU8     = 4'd1,
    FMT_CS16    = 4'd2,
    FMT_SC16Q11 = 4'd3,
    FMT_CS24    = 4'd4,
    FMT_CU16    = 4'd5,
    FMT_CS32    = 4'd6,
    FMT_CU32    = 4'd7,
    FMT_CF32    = 4'd8
  } fmt_t;

  // Configuration register indexes
  typedef logic [1:0] reg_index_t;
  localparam reg_index_t REG_FORMAT = 2'd0;
  localparam reg_index_t REG_GAIN   = 2'd1;

  localparam logic [3:0]  FORMAT_RESET = 4'd0;
  localparam logic [31:0] GAIN_RESET   = 32'h3F80_0000;
  localparam logic [31:0] CANON_NAN    = 32'h7FC0_0000;
  localparam logic [30:0] INF_MAG      = 31'h7F80_0000;

  // Register stages inside one lane, output register excluded
  localparam int LANE_STAGES = 6;

  // Signed binary exponent of an integer significand
  typedef logic signed [11:0] exp_t;

  // Gain operand as integer significand times a power of two
  typedef struct packed {
    logic        sign;
    logic        zero;
    logic        inf;
    logic        nan;
    logic [23:0] mant;
    exp_t        expo;
  } gain_t;

  // Class and mode bits travelling with a component down a lane
  typedef struct packed {
    logic sign;
    logic zero;
    logic inf;
    logic nan;
    logic undef;
    logic dbl;
  } lane_flags_t;

endpackage

`default_nettype wire

// ----- src/iqf_gain_prep.sv -----
// Gain operand register: unpacks the float32 gain, pre-scaled by 2^-23 for cs24.
// Depends on iqf_pkg.
`default_nettype none

module iqf_gain_prep (
  input  logic           clk,
  input  logic [3:0]     fmt,
  input  logic [31:0]    gain_bits,
  output iqf_pkg::gain_t gain
);
  import iqf_pkg::*;

  logic [7:0]  ef;
  logic [22:0] frac;
  logic        special;
  logic [23:0] mg;
  exp_t        eg;
  logic [4:0]  sa;
  logic [47:0] ext;
  logic [23:0] q;
  logic        gd;
  logic        st;
  gain_t       gain_next;

  assign ef      = gain_bits[30:23];
  assign frac    = gain_bits[22:0];
  assign special = (ef == 8'hFF);

  // Unpack, then for cs24 round g * 2^-23 to single where it goes subnormal
  always_comb begin
    mg  = (ef == 8'd0) ? {1'b0, frac} : {1'b1, frac};
    eg  = (ef == 8'd0) ? -12'sd149 : (exp_t'({4'b0, ef}) - 12'sd150);
    sa  = (ef == 8'd0) ? 5'd23 : 5'(8'd24 - ef);
    ext = {mg, 24'b0} >> sa;
    q   = ext[47:24];
    gd  = ext[23];
    st  = |ext[22:0];
    gain_next.sign = gain_bits[31];
    gain_next.inf  = special && (frac == 23'd0);
    gain_next.nan  = special && (frac != 23'd0);
    gain_next.mant = mg;
    gain_next.expo = eg;
    if (fmt == FMT_CS24 && !special) begin
      if (ef >= 8'd24) begin
        gain_next.expo = eg - 12'sd23;
      end else begin
        gain_next.mant = q + {23'b0, gd & (st | q[0])};
        gain_next.expo = -12'sd149;
      end
    end
    gain_next.zero = !special && (gain_next.mant == 24'd0);
  end

  always_ff @(posedge clk) begin
    gain <= gain_next;
  end

endmodule

`default_nettype wire

// ----- src/iqf_lane.sv -----
// One component lane: decode, gain multiply, normalise, optional rounding to
// double, subnormal alignment and final round to single. Depends on iqf_pkg.
`default_nettype none

module iqf_lane (
  input  logic           clk,
  input  logic [3:0]     fmt,
  input  logic [31:0]    raw,
  input  iqf_pkg::gain_t gain,
  output logic [31:0]    result
);
  import iqf_pkg::*;

  // Decode signals
  logic [31:0] sx;
  logic [31:0] dm;
  logic        sgn_fmt;
  exp_t        de;
  lane_flags_t df;
  logic [7:0]  xef;
  logic [22:0] xfr;

  // Stage registers
  logic [31:0] m1;
  exp_t        e1;
  lane_flags_t f1;
  logic [55:0] p2;
  exp_t        e2;
  lane_flags_t f2;
  logic [63:0] n3;
  logic [5:0]  c3;
  exp_t        e3;
  lane_flags_t f3;
  logic [63:0] n4;
  exp_t        e4;
  lane_flags_t f4;
  logic [63:0] n5;
  exp_t        e5;
  lane_flags_t f5;
  logic [23:0] mant6;
  logic        gd6;
  logic        st6;
  logic [7:0]  bef6;
  logic        big6;
  lane_flags_t f6;

  // Combinational next values
  lane_flags_t f2_next;
  logic [63:0] n3_next;
  logic [5:0]  c3_next;
  logic [63:0] n4_next;
  logic [5:0]  c4_next;
  logic [52:0] hi;
  logic        up;
  logic [53:0] sum54;
  logic [63:0] n5_next;
  exp_t        e5_next;
  exp_t        be;
  exp_t        diff;
  logic [4:0]  sh;
  logic [25:0] tv;
  logic [51:0] ext;
  logic        inc;
  logic [31:0] sum;
  logic [30:0] mag;

  assign xef = raw[30:23];
  assign xfr = raw[22:0];

  // Decode the raw word into sign, integer magnitude and exponent
  always_comb begin
    sx      = '0;
    dm      = '0;
    sgn_fmt = 1'b0;
    de      = '0;
    df      = '0;
    case (fmt)
      FMT_CS8: begin
        sgn_fmt = 1'b1;
        sx      = {{24{raw[7]}}, raw[7:0]};
        de      = -12'sd7;
      end
      FMT_CU8: begin
        df.sign = ~raw[7];
        dm      = {24'b0, (raw[7] ? raw[6:0] : ~raw[6:0]), 1'b1};
        de      = -12'sd8;
      end
      FMT_CS16: begin
        sgn_fmt = 1'b1;
        sx      = {{16{raw[15]}}, raw[15:0]};
        de      = -12'sd15;
      end
      FMT_SC16Q11: begin
        sgn_fmt = 1'b1;
        sx      = {{16{raw[15]}}, raw[15:0]};
        de      = -12'sd11;
      end
      FMT_CS24: begin
        sgn_fmt = 1'b1;
        sx      = {{8{raw[23]}}, raw[23:0]};
        de      = '0;
      end
      FMT_CU16: begin
        df.sign = ~raw[15];
        dm      = {16'b0, (raw[15] ? raw[14:0] : ~raw[14:0]), 1'b1};
        de      = -12'sd16;
      end
      FMT_CS32: begin
        sgn_fmt = 1'b1;
        sx      = raw;
        de      = -12'sd31;
      end
      FMT_CU32: begin
        df.sign = ~raw[31];
        dm      = {(raw[31] ? raw[30:0] : ~raw[30:0]), 1'b1};
        de      = -12'sd32;
      end
      FMT_CF32: begin
        df.sign = raw[31];
        df.inf  = (xef == 8'hFF) && (xfr == 23'd0);
        df.nan  = (xef == 8'hFF) && (xfr != 23'd0);
        dm      = (xef == 8'd0) ? {9'b0, xfr} : {8'b0, 1'b1, xfr};
        de      = (xef == 8'd0) ? -12'sd149 : (exp_t'({4'b0, xef}) - 12'sd150);
      end
      default: begin
        df.undef = 1'b1;
      end
    endcase
    if (sgn_fmt) begin
      df.sign = sx[31];
      dm      = sx[31] ? (~sx + 32'd1) : sx;
    end
    df.zero = (dm == 32'd0) && !df.inf && !df.nan;
    df.dbl  = fmt inside {FMT_CS32, FMT_CU32};
  end

  // Result class after the gain is applied
  always_comb begin
    f2_next       = f1;
    f2_next.sign  = f1.sign ^ gain.sign;
    f2_next.nan   = f1.nan || gain.nan || (f1.inf && gain.zero) || (f1.zero && gain.inf);
    f2_next.inf   = !f2_next.nan && (f1.inf || gain.inf);
    f2_next.zero  = !f2_next.nan && !f2_next.inf && (f1.zero || gain.zero);
  end

  // Normalise, coarse steps
  always_comb begin
    n3_next = {8'b0, p2};
    c3_next = '0;
    if (n3_next[63:32] == 32'd0) begin
      n3_next = n3_next << 32;
      c3_next = c3_next + 6'd32;
    end
    if (n3_next[63:48] == 16'd0) begin
      n3_next = n3_next << 16;
      c3_next = c3_next + 6'd16;
    end
    if (n3_next[63:56] == 8'd0) begin
      n3_next = n3_next << 8;
      c3_next = c3_next + 6'd8;
    end
  end

  // Normalise, fine steps
  always_comb begin
    n4_next = n3;
    c4_next = c3;
    if (n4_next[63:60] == 4'd0) begin
      n4_next = n4_next << 4;
      c4_next = c4_next + 6'd4;
    end
    if (n4_next[63:62] == 2'd0) begin
      n4_next = n4_next << 2;
      c4_next = c4_next + 6'd2;
    end
    if (!n4_next[63]) begin
      n4_next = n4_next << 1;
      c4_next = c4_next + 6'd1;
    end
  end

  // Round to 53 bits for the 32-bit integer formats
  always_comb begin
    hi      = n4[63:11];
    up      = n4[10] && ((|n4[9:0]) || hi[0]);
    sum54   = {1'b0, hi} + {53'b0, up};
    n5_next = n4;
    e5_next = e4;
    if (f4.dbl) begin
      if (sum54[53]) begin
        n5_next = {1'b1, 63'b0};
        e5_next = e4 + 12'sd1;
      end else begin
        n5_next = {sum54[52:0], 11'b0};
      end
    end
  end

  // Align to single, denormalising below the normal range
  always_comb begin
    be   = e5 + 12'sd127;
    diff = 12'sd1 - be;
    if (be >= 12'sd1) begin
      sh = 5'd0;
    end else if (diff > 12'sd26) begin
      sh = 5'd26;
    end else begin
      sh = diff[4:0];
    end
    tv  = {n5[63:39], |n5[38:0]};
    ext = {tv, 26'b0} >> sh;
  end

  // Final round to nearest even; carry runs into the exponent field
  always_comb begin
    inc = gd6 && (st6 || mant6[0]);
    sum = {1'b0, bef6, 23'b0} + {8'b0, mant6} + {31'b0, inc};
    mag = big6 ? INF_MAG : sum[30:0];
    if (f6.undef) begin
      result = 32'd0;
    end else if (f6.nan) begin
      result = CANON_NAN;
    end else if (f6.inf) begin
      result = {f6.sign, INF_MAG};
    end else if (f6.zero) begin
      result = {f6.sign, 31'b0};
    end else begin
      result = {f6.sign, mag};
    end
  end

  // Pipeline registers
  always_ff @(posedge clk) begin
    m1    <= dm;
    e1    <= de;
    f1    <= df;
    p2    <= {24'b0, m1} * {32'b0, gain.mant};
    e2    <= e1 + gain.expo;
    f2    <= f2_next;
    n3    <= n3_next;
    c3    <= c3_next;
    e3    <= e2;
    f3    <= f2;
    n4    <= n4_next;
    e4    <= e3 + 12'sd63 - exp_t'({6'b0, c4_next});
    f4    <= f3;
    n5    <= n5_next;
    e5    <= e5_next;
    f5    <= f4;
    mant6 <= ext[51:28];
    gd6   <= ext[27];
    st6   <= ext[26] || (|ext[25:0]);
    bef6  <= (be >= 12'sd1) ? (be[7:0] - 8'd1) : 8'd0;
    big6  <= (be > 12'sd254);
    f6    <= f5;
  end

endmodule

`default_nettype wire

// ----- src/iq_int_to_float_converter.sv -----
// A request's done strobe travels down a valid shift register beside the lanes and is
// registered together with the lane results in the output register.
// Throughput: one complex frame per cycle, both components in parallel lanes,
// each a 6-stage pipeline plus a shared output register. busy follows rst only.
// Reset clears format (cs8), gain (1.0) and all strobes; no clearing pass.
// Depends on iqf_pkg, iqf_gain_prep and iqf_lane.
`default_nettype none

module iq_int_to_float_converter (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [31:0]         raw_inphase,
  input  logic [31:0]         raw_quadrature,
  input  logic                frame_last,
  output logic                done,
  output logic [31:0]         float_inphase,
  output logic [31:0]         float_quadrature,
  output logic                result_last,
  input  logic                cfg_write,
  input  iqf_pkg::reg_index_t cfg_index,
  input  logic [31:0]         cfg_data
);
  import iqf_pkg::*;

  logic [3:0]             sample_format;
  logic [31:0]            gain_bits;
  gain_t                  gain;
  logic                   accept;
  logic [LANE_STAGES-1:0] vld;
  logic [LANE_STAGES-1:0] lst;
  logic [31:0]            res_i;
  logic [31:0]            res_q;

  assign busy   = rst;
  assign accept = start && !busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= FORMAT_RESET;
      gain_bits     <= GAIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FORMAT: sample_format <= cfg_data[3:0];
        REG_GAIN:   gain_bits     <= cfg_data;
        default: ;
      endcase
    end
  end

  iqf_gain_prep u_gain (
    .clk       (clk),
    .fmt       (sample_format),
    .gain_bits (gain_bits),
    .gain      (gain)
  );

  iqf_lane u_lane_i (
    .clk    (clk),
    .fmt    (sample_format),
    .raw    (raw_inphase),
    .gain   (gain),
    .result (res_i)
  );

  iqf_lane u_lane_q (
    .clk    (clk),
    .fmt    (sample_format),
    .raw    (raw_quadrature),
    .gain   (gain),
    .result (res_q)
  );

  // Request tracking alongside the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[LANE_STAGES-2:0], accept};
      done <= vld[LANE_STAGES-1];
    end
  end

  // Merge both lanes and the end-of-block mark into the output register
  always_ff @(posedge clk) begin
    lst              <= {lst[LANE_STAGES-2:0], frame_last};
    result_last      <= lst[LANE_STAGES-1];
    float_inphase    <= res_i;
    float_quadrature <= res_q;
  end

  // Every strobe belongs to an accepted request, its end-of-block mark carried along
  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(accept, 7) && (result_last == $past(frame_last, 7))))
    else $error("result strobe without matching request");

  // NaN results leave only in canonical form
  a_nan_canon_i: assert property (@(posedge clk) disable iff (rst)
    (done && (float_inphase[30:23] == 8'hFF) && (float_inphase[22:0] != 23'd0))
      |-> (float_inphase == CANON_NAN))
    else $error("non-canonical NaN on in-phase output");

  a_nan_canon_q: assert property (@(posedge clk) disable iff (rst)
    (done && (float_quadrature[30:23] == 8'hFF) && (float_quadrature[22:0] != 23'd0))
      |-> (float_quadrature == CANON_NAN))
    else $error("non-canonical NaN on quadrature output");

endmodule

`default_nettype wire
